/* rtl/dmds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmds_pkg
// Types and fixed widths shared by the depth min-downsample unit.
// ----------------------------------------------------------------------------
package dmds_pkg;

  localparam int SW_W = 11;
  localparam int SH_W = 10;
  localparam int TW_W = 11;
  localparam int TH_W = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HEIGHT = 2'd3;

  localparam logic [SW_W-1:0] SOURCE_WIDTH_RESET  = 11'd640;
  localparam logic [SH_W-1:0] SOURCE_HEIGHT_RESET = 10'd480;
  localparam logic [TW_W-1:0] TARGET_WIDTH_RESET  = 11'd320;
  localparam logic [TH_W-1:0] TARGET_HEIGHT_RESET = 10'd240;

  localparam int COL_W = 10;
  localparam int ROW_W = 9;
  localparam int IN_DEPTH_W = 16;
  localparam int OUT_DEPTH_W = 16;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // numerator S*(2o+1)+D and denominator 2D per axis
  localparam int XNUM_W = SW_W + COL_W + 2;
  localparam int XDEN_W = TW_W + 1;
  localparam int YNUM_W = SH_W + ROW_W + 2;
  localparam int YDEN_W = TH_W + 1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                  action;
    logic [COL_W-1:0]      column;
    logic [ROW_W-1:0]      row;
    logic [IN_DEPTH_W-1:0] depth_in;
  } item_t;

  typedef struct packed {
    logic [OUT_DEPTH_W-1:0] depth_out;
    logic                   found;
  } result_t;

  typedef struct packed {
    logic [SW_W-1:0] source_width;
    logic [SH_W-1:0] source_height;
    logic [TW_W-1:0] target_width;
    logic [TH_W-1:0] target_height;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_QUERY,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SW_W-1:0]       x0;
    logic [SW_W-1:0]       x1;
    logic [SH_W-1:0]       y0;
    logic [SH_W-1:0]       y1;
    logic [IN_DEPTH_W-1:0] depth;
  } entry_t;

endpackage

/* rtl/dmds_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmds_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dmds_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dmds_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             valid
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] count;
  logic             running;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      valid   <= 1'b0;
    end else if (start) begin
      quo     <= num;
      den_r   <= den;
      rem     <= '0;
      count   <= '0;
      running <= 1'b1;
      valid   <= 1'b0;
    end else if (running) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo   <= {quo[NUM_W-2:0], fits};
      count <= count + CNT_W'(1);
      if (count == CNT_W'(NUM_W - 1)) begin
        running <= 1'b0;
        valid   <= 1'b1;
      end
    end
  end

endmodule

/* rtl/dmds_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmds_queue
// Short FIFO of command words between the front and back ends.
// ----------------------------------------------------------------------------
module dmds_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dmds_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output dmds_pkg::entry_t pop_data,
  output logic             empty
);

  localparam int DEPTH = dmds_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dmds_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full     = count == CNT_W'(DEPTH);
    empty    = count == '0;
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_data = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/dmds_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmds_front
// Accept input words, classify them and work out query window bounds.
// ----------------------------------------------------------------------------
module dmds_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dmds_pkg::item_t  item,
  input  dmds_pkg::cfg_t   cfg,
  output logic             busy,
  output logic             push,
  output dmds_pkg::entry_t push_data,
  input  logic             q_full
);

  localparam int SW_W   = dmds_pkg::SW_W;
  localparam int SH_W   = dmds_pkg::SH_W;
  localparam int COL_W  = dmds_pkg::COL_W;
  localparam int ROW_W  = dmds_pkg::ROW_W;
  localparam int XNUM_W = dmds_pkg::XNUM_W;
  localparam int XDEN_W = dmds_pkg::XDEN_W;
  localparam int YNUM_W = dmds_pkg::YNUM_W;
  localparam int YDEN_W = dmds_pkg::YDEN_W;
  localparam int XP_W   = XNUM_W - 1;
  localparam int YP_W   = YNUM_W - 1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_START,
    F_DIV,
    F_FIN
  } state_t;

  state_t state;

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [XP_W-1:0]   prod_x;
  logic [YP_W-1:0]   prod_y;
  logic [SW_W-1:0]   sw;
  logic [SH_W-1:0]   sh;
  logic              size_zero;
  logic              accept;
  logic              div_start;
  logic [XNUM_W-1:0] hi_num_x;
  logic [XNUM_W-1:0] lo_num_x;
  logic [XNUM_W-1:0] two_sw;
  logic [YNUM_W-1:0] hi_num_y;
  logic [YNUM_W-1:0] lo_num_y;
  logic [YNUM_W-1:0] two_sh;
  logic [XDEN_W-1:0] den_x;
  logic [YDEN_W-1:0] den_y;
  logic [XNUM_W-1:0] lx_quo;
  logic [XNUM_W-1:0] hx_quo;
  logic [YNUM_W-1:0] ly_quo;
  logic [YNUM_W-1:0] hy_quo;
  logic              lx_valid;
  logic              hx_valid;
  logic              ly_valid;
  logic              hy_valid;
  logic              divs_done;
  logic              off_x;
  logic              off_y;
  logic [SW_W-1:0]   lo_x;
  logic [SW_W-1:0]   hi_x;
  logic [SH_W-1:0]   lo_y;
  logic [SH_W-1:0]   hi_y;
  dmds_pkg::entry_t  fin_entry;

  always_comb begin
    sw = (int'(cfg.source_width) > MAX_COLUMNS) ? SW_W'(MAX_COLUMNS) : cfg.source_width;
    sh = (int'(cfg.source_height) > MAX_ROWS) ? SH_W'(MAX_ROWS) : cfg.source_height;
    size_zero = (sw == '0) || (sh == '0) || (cfg.target_width == '0) ||
                (cfg.target_height == '0);
    busy   = (state != F_IDLE) || q_full;
    accept = start && !busy;

    // hi numerator S*(2o+1)+D, lo numerator is that minus 2S, floored at zero
    two_sw   = XNUM_W'({sw, 1'b0});
    two_sh   = YNUM_W'({sh, 1'b0});
    hi_num_x = XNUM_W'(prod_x) + XNUM_W'(cfg.target_width);
    hi_num_y = YNUM_W'(prod_y) + YNUM_W'(cfg.target_height);
    lo_num_x = (hi_num_x < two_sw) ? '0 : hi_num_x - two_sw;
    lo_num_y = (hi_num_y < two_sh) ? '0 : hi_num_y - two_sh;
    den_x    = {cfg.target_width, 1'b0};
    den_y    = {cfg.target_height, 1'b0};
    div_start = state == F_START;
    divs_done = lx_valid && hx_valid && ly_valid && hy_valid;

    off_x = lx_quo >= XNUM_W'(sw);
    off_y = ly_quo >= YNUM_W'(sh);
    lo_x  = SW_W'(lx_quo);
    lo_y  = SH_W'(ly_quo);
    hi_x  = (hx_quo > XNUM_W'(sw - SW_W'(1))) ? sw - SW_W'(1) : SW_W'(hx_quo);
    hi_y  = (hy_quo > YNUM_W'(sh - SH_W'(1))) ? sh - SH_W'(1) : SH_W'(hy_quo);
    if (hi_x < lo_x) begin
      hi_x = lo_x;
    end
    if (hi_y < lo_y) begin
      hi_y = lo_y;
    end

    fin_entry       = '0;
    fin_entry.kind  = (off_x || off_y) ? dmds_pkg::KIND_EMPTY : dmds_pkg::KIND_QUERY;
    fin_entry.x0    = lo_x;
    fin_entry.x1    = hi_x;
    fin_entry.y0    = lo_y;
    fin_entry.y1    = hi_y;

    push      = 1'b0;
    push_data = '0;
    if ((state == F_IDLE) && accept) begin
      if (item.action == dmds_pkg::ACT_LOAD) begin
        push_data.kind  = dmds_pkg::KIND_LOAD;
        push_data.x0    = SW_W'(item.column);
        push_data.y0    = SH_W'(item.row);
        push_data.depth = item.depth_in;
        push = (int'(item.column) < MAX_COLUMNS) && (int'(item.row) < MAX_ROWS);
      end else if (size_zero) begin
        push_data.kind = dmds_pkg::KIND_EMPTY;
        push = 1'b1;
      end
    end else if ((state == F_FIN) && !q_full) begin
      push_data = fin_entry;
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && (item.action == dmds_pkg::ACT_QUERY) && !size_zero) begin
            col_r <= item.column;
            row_r <= item.row;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod_x <= XP_W'(sw) * XP_W'({col_r, 1'b1});
          prod_y <= YP_W'(sh) * YP_W'({row_r, 1'b1});
          state  <= F_START;
        end
        F_START: begin
          state <= F_DIV;
        end
        F_DIV: begin
          if (divs_done) begin
            state <= F_FIN;
          end
        end
        F_FIN: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  dmds_div #(.NUM_W(XNUM_W), .DEN_W(XDEN_W)) u_div_lx (
    .clk(clk), .rst(rst), .start(div_start), .num(lo_num_x), .den(den_x),
    .quo(lx_quo), .valid(lx_valid)
  );

  dmds_div #(.NUM_W(XNUM_W), .DEN_W(XDEN_W)) u_div_hx (
    .clk(clk), .rst(rst), .start(div_start), .num(hi_num_x), .den(den_x),
    .quo(hx_quo), .valid(hx_valid)
  );

  dmds_div #(.NUM_W(YNUM_W), .DEN_W(YDEN_W)) u_div_ly (
    .clk(clk), .rst(rst), .start(div_start), .num(lo_num_y), .den(den_y),
    .quo(ly_quo), .valid(ly_valid)
  );

  dmds_div #(.NUM_W(YNUM_W), .DEN_W(YDEN_W)) u_div_hy (
    .clk(clk), .rst(rst), .start(div_start), .num(hi_num_y), .den(den_y),
    .quo(hy_quo), .valid(hy_valid)
  );

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("front pushed into a full queue");

  a_fin_ready: assert property (@(posedge clk) disable iff (rst)
    (state == F_FIN) |-> divs_done)
    else $error("window bounds used before the dividers finished");
`endif

endmodule

/* rtl/dmds_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmds_back
// Execute queued words: write samples, walk query windows for the min depth.
// ----------------------------------------------------------------------------
module dmds_back #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 512,
  parameter int DEPTH_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  output logic              pop,
  input  dmds_pkg::entry_t  head,
  input  logic              q_empty,
  output logic              done,
  output dmds_pkg::result_t result
);

  localparam int SW_W        = dmds_pkg::SW_W;
  localparam int SH_W        = dmds_pkg::SH_W;
  localparam int OUT_DEPTH_W = dmds_pkg::OUT_DEPTH_W;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_DRAIN
  } state_t;

  state_t state;

  logic [SW_W-1:0]       x;
  logic [SW_W-1:0]       x0_r;
  logic [SW_W-1:0]       x1_r;
  logic [SH_W-1:0]       y;
  logic [SH_W-1:0]       y1_r;
  logic [ADDR_W-1:0]     row_base;
  logic                  rd_pend;
  logic                  rd_last;
  logic [DEPTH_BITS-1:0] best;
  logic                  found;
  logic [DEPTH_BITS-1:0] best_next;
  logic                  found_next;
  logic                  take;
  logic                  is_last;
  logic                  empty_pop;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [DEPTH_BITS-1:0] mem_rdata;

  always_comb begin
    pop       = (state == B_IDLE) && !q_empty;
    mem_we    = pop && (head.kind == dmds_pkg::KIND_LOAD);
    empty_pop = pop && (head.kind == dmds_pkg::KIND_EMPTY);
    mem_waddr = ADDR_W'(int'(head.y0) * MAX_COLUMNS + int'(head.x0));
    mem_wdata = DEPTH_BITS'(head.depth);
    mem_re    = state == B_WALK;
    mem_raddr = row_base + ADDR_W'(x);
    is_last   = (x == x1_r) && (y == y1_r);

    // zero depth is a hole: skip it
    take       = rd_pend && (mem_rdata != '0) && (!found || (mem_rdata < best));
    best_next  = take ? mem_rdata : best;
    found_next = found || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= state == B_WALK;
      rd_last <= is_last;
      if (rd_pend) begin
        best  <= best_next;
        found <= found_next;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            case (head.kind)
              dmds_pkg::KIND_QUERY: begin
                x        <= head.x0;
                x0_r     <= head.x0;
                x1_r     <= head.x1;
                y        <= head.y0;
                y1_r     <= head.y1;
                row_base <= ADDR_W'(int'(head.y0) * MAX_COLUMNS);
                best     <= '0;
                found    <= 1'b0;
                state    <= B_WALK;
              end
              dmds_pkg::KIND_EMPTY: begin
                done   <= 1'b1;
                result <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        B_WALK: begin
          if (x == x1_r) begin
            x        <= x0_r;
            y        <= y + SH_W'(1);
            row_base <= row_base + ADDR_W'(MAX_COLUMNS);
          end else begin
            x <= x + SW_W'(1);
          end
          if (is_last) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          done             <= 1'b1;
          result.depth_out <= OUT_DEPTH_W'(best_next);
          result.found     <= found_next;
          state            <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  dmds_ram #(.WIDTH(DEPTH_BITS), .DEPTH(STORE_DEPTH)) u_frame_store (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

`ifndef NO_ASSERTIONS
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> (($past(rd_pend) && $past(rd_last)) || $past(empty_pop)))
    else $error("result word without a finished window or empty query");

  a_drain_data: assert property (@(posedge clk) disable iff (rst)
    (state == B_DRAIN) |-> (rd_pend && rd_last))
    else $error("drain reached without the last sample in flight");

  a_walk_idle_queue: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> !mem_we)
    else $error("sample write during a window walk");
`endif

endmodule

/* rtl/depth_min_downsample_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_min_downsample_unit
// Depth frame resampler: store depth samples, answer min-pooled output pixels.
// ----------------------------------------------------------------------------
// A load word (action 0) is pushed into the command queue when accepted and is
// written to the frame store when the back end pops it; loads can follow each
// other every cycle while the two-entry command queue has room. A query word
// (action 1) holds busy while the front end forms its window bounds with four
// restoring dividers, one quotient bit per cycle over the 23-bit x and 21-bit y
// numerators; with a zero frame size it is queued as an empty query instead. The
// back end then reads the frame store one sample per cycle, after which the
// result word shows on result with done high for one cycle. The receiver cannot
// stall: each result word must be taken in the cycle that done is high. Words
// come back in the order they were accepted.
module depth_min_downsample_unit #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 512,
  parameter int DEPTH_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  dmds_pkg::item_t                      item,
  output logic                                 busy,
  output logic                                 done,
  output dmds_pkg::result_t                    result,
  input  logic                                 cfg_write,
  input  logic [dmds_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dmds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dmds_pkg::cfg_t   cfg;
  dmds_pkg::entry_t push_data;
  dmds_pkg::entry_t head;
  logic             push;
  logic             q_full;
  logic             pop;
  logic             q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= dmds_pkg::SOURCE_WIDTH_RESET;
      cfg.source_height <= dmds_pkg::SOURCE_HEIGHT_RESET;
      cfg.target_width  <= dmds_pkg::TARGET_WIDTH_RESET;
      cfg.target_height <= dmds_pkg::TARGET_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dmds_pkg::CFG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data[dmds_pkg::SW_W-1:0];
        dmds_pkg::CFG_SOURCE_HEIGHT: cfg.source_height <= cfg_data[dmds_pkg::SH_W-1:0];
        dmds_pkg::CFG_TARGET_WIDTH:  cfg.target_width  <= cfg_data[dmds_pkg::TW_W-1:0];
        dmds_pkg::CFG_TARGET_HEIGHT: cfg.target_height <= cfg_data[dmds_pkg::TH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dmds_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .cfg(cfg),
    .busy(busy),
    .push(push),
    .push_data(push_data),
    .q_full(q_full)
  );

  dmds_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(q_full),
    .pop(pop),
    .pop_data(head),
    .empty(q_empty)
  );

  dmds_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .pop(pop),
    .head(head),
    .q_empty(q_empty),
    .done(done),
    .result(result)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth min-downsample unit. Drives load and query
// words with random gaps, predicts each min-pooled pixel from a private copy
// of the frame store and the frame sizes, and checks every result word in
// order. Runs a short directed prologue, then random traffic under a series
// of frame size settings that include zero and oversized frames.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COLS = 1024;
  localparam int ROWS = 512;
  localparam int SETTLE = 16;
  localparam int TAIL = 64;
  localparam int MAX_AREA = 64;
  localparam int LIMIT = 500000;

  class min_depth_board;
    logic [dmds_pkg::IN_DEPTH_W-1:0] depth_mem [COLS*ROWS];
    bit                              filled [COLS*ROWS];
    int unsigned                     src_w, src_h, dst_w, dst_h;
    dmds_pkg::result_t               expected_minima [$];
    int                              fail_count;

    function new();
      src_w = dmds_pkg::SOURCE_WIDTH_RESET;
      src_h = dmds_pkg::SOURCE_HEIGHT_RESET;
      dst_w = dmds_pkg::TARGET_WIDTH_RESET;
      dst_h = dmds_pkg::TARGET_HEIGHT_RESET;
      fail_count = 0;
    endfunction

    function void set_reg(logic [dmds_pkg::CFG_INDEX_W-1:0] idx,
                          logic [dmds_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dmds_pkg::CFG_SOURCE_WIDTH:  src_w = data[dmds_pkg::SW_W-1:0];
        dmds_pkg::CFG_SOURCE_HEIGHT: src_h = data[dmds_pkg::SH_W-1:0];
        dmds_pkg::CFG_TARGET_WIDTH:  dst_w = data[dmds_pkg::TW_W-1:0];
        dmds_pkg::CFG_TARGET_HEIGHT: dst_h = data[dmds_pkg::TH_W-1:0];
        default: ;
      endcase
    endfunction

    function bit axis_span(longint s, longint d, longint o,
                           output int unsigned lo, output int unsigned hi);
      longint den, num_lo, num_hi, l, h;
      den = 2 * d;
      num_lo = s * (2 * o - 1) + d;
      num_hi = s * (2 * o + 1) + d;
      l = (num_lo < 0) ? 0 : num_lo / den;
      h = num_hi / den;
      if (l >= s) return 1'b0;
      if (h > s - 1) h = s - 1;
      if (h < l) h = l;
      lo = int'(l);
      hi = int'(h);
      return 1'b1;
    endfunction

    function bit window_of(int unsigned col, int unsigned row,
                           output int unsigned x0, output int unsigned x1,
                           output int unsigned y0, output int unsigned y1);
      int unsigned sw, sh;
      sw = (src_w > COLS) ? COLS : src_w;
      sh = (src_h > ROWS) ? ROWS : src_h;
      if (sw == 0 || sh == 0 || dst_w == 0 || dst_h == 0) return 1'b0;
      if (!axis_span(sw, dst_w, col, x0, x1)) return 1'b0;
      return axis_span(sh, dst_h, row, y0, y1);
    endfunction

    function dmds_pkg::result_t pool_window_min(int unsigned col, int unsigned row);
      dmds_pkg::result_t               r;
      int unsigned                     x0, x1, y0, y1;
      logic [dmds_pkg::IN_DEPTH_W-1:0] v;
      r = '0;
      if (window_of(col, row, x0, x1, y0, y1)) begin
        for (int unsigned y = y0; y <= y1; y++) begin
          for (int unsigned x = x0; x <= x1; x++) begin
            v = depth_mem[y * COLS + x];
            if (v != 0 && (!r.found || v < r.depth_out)) begin
              r.depth_out = v;
              r.found = 1'b1;
            end
          end
        end
      end
      return r;
    endfunction

    function void note_word(dmds_pkg::item_t w);
      int unsigned addr;
      addr = int'(w.row) * COLS + int'(w.column);
      if (w.action == dmds_pkg::ACT_LOAD) begin
        depth_mem[addr] = w.depth_in;
        filled[addr] = 1'b1;
      end else begin
        expected_minima.push_back(pool_window_min(w.column, w.row));
      end
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(dmds_pkg::result_t got);
      dmds_pkg::result_t exp;
      if (expected_minima.size() == 0) begin
        note_failure($sformatf("unexpected result: depth_out %0d found %0b",
                               got.depth_out, got.found));
        return;
      end
      exp = expected_minima.pop_front();
      if (got.depth_out !== exp.depth_out || got.found !== exp.found)
        note_failure($sformatf("depth_out expected %0d got %0d, found expected %0b got %0b",
                               exp.depth_out, got.depth_out, exp.found, got.found));
    endfunction

    function void close_out();
      if (expected_minima.size() != 0)
        note_failure($sformatf("%0d results never came", expected_minima.size()));
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             start;
  dmds_pkg::item_t                  item;
  logic                             busy;
  logic                             done;
  dmds_pkg::result_t                result;
  logic                             cfg_write;
  logic [dmds_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dmds_pkg::CFG_DATA_W-1:0]  cfg_data;

  min_depth_board board;
  int             words_sent = 0;
  int             cycles = 0;
  bit             steady = 1'b0;

  depth_min_downsample_unit uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("depth_min_downsample_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) board.check_result(result);
  end

  function automatic logic [dmds_pkg::IN_DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return dmds_pkg::IN_DEPTH_W'($urandom_range(1, 15));
      2: return '1;
      default: return dmds_pkg::IN_DEPTH_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(input dmds_pkg::item_t w);
    int gap;
    if ($urandom_range(0, 19) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(w);
    words_sent++;
  endtask

  task automatic send_load(input int unsigned col, input int unsigned row,
                           input logic [dmds_pkg::IN_DEPTH_W-1:0] depth);
    dmds_pkg::item_t w;
    w.action = dmds_pkg::ACT_LOAD;
    w.column = col[dmds_pkg::COL_W-1:0];
    w.row = row[dmds_pkg::ROW_W-1:0];
    w.depth_in = depth;
    send_word(w);
  endtask

  task automatic send_query(input int unsigned col, input int unsigned row);
    dmds_pkg::item_t w;
    w.action = dmds_pkg::ACT_QUERY;
    w.column = col[dmds_pkg::COL_W-1:0];
    w.row = row[dmds_pkg::ROW_W-1:0];
    w.depth_in = dmds_pkg::IN_DEPTH_W'($urandom_range(0, 65535));
    send_word(w);
  endtask

  // load unwritten window samples, query; over MAX_AREA: just one random load
  task automatic query_with_fill(input int unsigned col, input int unsigned row);
    int unsigned x0, x1, y0, y1;
    if (board.window_of(col, row, x0, x1, y0, y1)) begin
      if ((x1 - x0 + 1) * (y1 - y0 + 1) > MAX_AREA) begin
        send_load($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1), pick_depth());
        return;
      end
      for (int unsigned y = y0; y <= y1; y++)
        for (int unsigned x = x0; x <= x1; x++)
          if (!board.filled[y * COLS + x]) send_load(x, y, pick_depth());
    end
    send_query(col, row);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.expected_minima.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dmds_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[dmds_pkg::CFG_DATA_W-1:0];
    board.set_reg(idx, val[dmds_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic program_frame(input int unsigned sw, input int unsigned sh,
                               input int unsigned tw, input int unsigned th);
    drain();
    repeat (SETTLE) @(posedge clk);
    write_reg(dmds_pkg::CFG_SOURCE_WIDTH, sw);
    write_reg(dmds_pkg::CFG_SOURCE_HEIGHT, sh);
    write_reg(dmds_pkg::CFG_TARGET_WIDTH, tw);
    write_reg(dmds_pkg::CFG_TARGET_HEIGHT, th);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_step();
    int unsigned pick, col, row, lim_c, lim_r;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      col = $urandom_range(0, COLS - 1);
      row = $urandom_range(0, ROWS - 1);
      if (board.dst_w != 0 && $urandom_range(0, 4) != 0)
        col = $urandom_range(0, ((board.dst_w > COLS) ? COLS : board.dst_w) - 1);
      if (board.dst_h != 0 && $urandom_range(0, 4) != 0)
        row = $urandom_range(0, ((board.dst_h > ROWS) ? ROWS : board.dst_h) - 1);
      query_with_fill(col, row);
    end else if (pick < 80) begin
      lim_c = (board.src_w == 0) ? COLS : ((board.src_w > COLS) ? COLS : board.src_w);
      lim_r = (board.src_h == 0) ? ROWS : ((board.src_h > ROWS) ? ROWS : board.src_h);
      send_load($urandom_range(0, lim_c - 1), $urandom_range(0, lim_r - 1), pick_depth());
    end else begin
      send_load($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1), pick_depth());
    end
    if ($urandom_range(0, 39) == 0) drain();
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) random_step();
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_load(0, 0, 16'h0000);
    send_load(1, 0, 16'hFFFF);
    send_load(0, 1, 16'h0001);
    send_load(1, 1, 16'h8000);
    send_query(0, 0);
    send_load(1023, 511, 16'hFFFF);
    send_load(682, 300, 16'h5555);
    send_load(341, 170, 16'hAAAA);
    send_query(1023, 511);
    query_with_fill(319, 239);
    send_load(0, 1, 16'h0000);
    send_load(1, 0, 16'h0000);
    send_load(1, 1, 16'h0000);
    send_query(0, 0);

    run_random(60);
    program_frame(1024, 512, 512, 256);
    run_random(60);
    program_frame(1, 1, 1024, 512);
    run_random(40);
    program_frame(2047, 1023, 1024, 512);
    run_random(60);
    program_frame(37, 23, 16, 9);
    run_random(60);
    program_frame(0, 480, 320, 240);
    run_random(20);
    program_frame(5, 5, 0, 3);
    run_random(20);
    program_frame(7, 300, 3, 0);
    run_random(15);
    program_frame(1, 1, 1, 1);
    run_random(30);
    program_frame(100, 60, 33, 41);
    run_random(60);
    program_frame(640, 480, 320, 240);
    run_random(40);

    drain();
    repeat (TAIL) @(posedge clk);
    board.close_out();
    if (board.fail_count == 0)
      $display("depth_min_downsample_unit: match");
    else
      $display("depth_min_downsample_unit: mismatch");
    $finish;
  end

endmodule
